[src/bsc_pkg.sv]
`timescale 1ns / 1ps

package bsc_pkg;

	// oversampling setting of the sensor (0..3)
	localparam logic [1:0] OVERSAMPLING = 2'd0;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	// register indexes of the configuration port
	localparam logic [2:0] REG_AC1  = 3'd0;
	localparam logic [2:0] REG_AC2  = 3'd1;
	localparam logic [2:0] REG_AC3  = 3'd2;
	localparam logic [2:0] REG_AC4  = 3'd3;
	localparam logic [2:0] REG_B1   = 3'd4;
	localparam logic [2:0] REG_B2   = 3'd5;
	localparam logic [2:0] REG_SCAL = 3'd6;
	localparam logic [2:0] REG_FIT  = 3'd7;

	// compensation constants
	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] X3_BIAS   = 32'd32768;
	localparam logic [31:0] UP_SCALE  = 32'd50000 >> OVERSAMPLING;
	localparam logic [31:0] OSS_MUL   = 32'd1 << OVERSAMPLING;
	localparam logic [31:0] K_3038    = 32'd3038;
	localparam logic [31:0] K_M7357   = 32'hFFFF_E343;
	localparam logic [31:0] K_3791    = 32'd3791;
	localparam logic [31:0] K_2048    = 32'd2048;

	localparam int unsigned STEP_W = 5;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [2:0] {
		DST_A,
		DST_B,
		DST_C,
		DST_D,
		DST_E,
		DST_B5
	} dst_t;

	// one micro-operation of the sequencer
	typedef struct packed {
		alu_op_t    op;
		logic [4:0] sh;
		logic       lsr;
		dst_t       dst;
		logic       div;
		logic       div_sgn;
		logic       last;
	} uop_t;

	typedef struct packed {
		logic start;
		logic sgn;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

[src/bsc_alu.sv]
`timescale 1ns / 1ps

// shared arithmetic unit: multiply (low word), add or subtract, then right shift
module bsc_alu (
	input  bsc_pkg::alu_op_t op,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	input  logic [4:0]       sh,
	input  logic             lsr,
	output logic [31:0]      y
);
	import bsc_pkg::*;

	logic [31:0] pre;

	// operation select
	always_comb begin
		case (op)
			ALU_MUL: pre = a * b;
			ALU_ADD: pre = a + b;
			ALU_SUB: pre = a - b;
			default: pre = a + b;
		endcase
	end

	// logical or arithmetic shift
	assign y = lsr ? (pre >> sh) : 32'($signed(pre) >>> sh);

endmodule

[src/bsc_div.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, optional signed mode
// (truncates toward zero)
module bsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bsc_pkg::div_ctl_t ctl,
	input  logic [31:0]       dividend,
	input  logic [31:0]       divisor,
	output bsc_pkg::div_sts_t sts,
	output logic [31:0]       quotient
);
	import bsc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [33:0] trial;
	logic [31:0] num_abs;
	logic [31:0] den_abs;

	// magnitudes of the operands
	assign num_abs = (ctl.sgn && dividend[31]) ? (~dividend + 32'd1) : dividend;
	assign den_abs = (ctl.sgn && divisor[31]) ? (~divisor + 32'd1) : divisor;

	// trial subtract of the shifted remainder
	assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q <= ctl.sgn && (dividend[31] ^ divisor[31]);
			rem_q <= '0;
			quo_q <= num_abs;
			den_q <= den_abs;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = neg_q ? (~quo_q + 32'd1) : quo_q;

endmodule

[src/barometric_sensor_compensation_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: cmd; tdata: raw_value
// m_*       out  m_tvalid/m_tready  tuser: kind, divide_error; tdata: temperature, pressure
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One word at a time: a word is worked through all its steps before it gives its
// result, and the next word is taken only once the sequencer is idle again.
// A division runs a start, 32 bit steps and a write-back; every other step is one
// shared ALU operation. A zero divisor skips the division.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer stalls on its last step if that is still full.
// Reset clears all calibration words and the stored B5.
module barometric_sensor_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [18:0] raw_value, rest zero
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] temperature_tenths, [47:16] pressure_pa
	output logic [1:0]  m_tuser,   // [0] kind, [1] divide_error
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DIVW = 3'b100
	} state_t;

	state_t              state_q;
	logic                kind_q;
	logic [18:0]         raw_q;
	logic [STEP_W-1:0]   step_q;
	logic                err_q;

	// calibration words and kept B5
	logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, b1_q, b2_q;
	logic [31:0] scale_q, fit_q, b5_q;

	// working registers
	logic [31:0] ta_q, tb_q, tc_q, td_q, te_q;

	// output register
	logic        m_tvalid_q;
	logic        out_kind_q;
	logic        out_err_q;
	logic [15:0] out_temp_q;
	logic [31:0] out_press_q;

	uop_t        uop;
	logic [31:0] alu_a, alu_b, alu_y;
	logic [31:0] div_q;
	div_ctl_t    div_ctl;
	div_sts_t    div_sts;
	logic        out_free;
	logic        div_zero;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [15:0] temp_sat;

	// micro-program: one ALU operation or one division per step
	always_comb begin
		uop   = '{op: ALU_ADD, sh: 5'd0, lsr: 1'b0, dst: DST_E,
		          div: 1'b0, div_sgn: 1'b0, last: 1'b0};
		alu_a = '0;
		alu_b = '0;
		if (kind_q == CMD_TEMP) begin
			case (step_q)
				5'd0: begin
					uop.op = ALU_SUB; uop.dst = DST_A;
					alu_a = {16'd0, raw_q[15:0]}; alu_b = {16'd0, scale_q[15:0]};
				end
				5'd1: begin
					uop.op = ALU_MUL; uop.sh = 5'd15; uop.dst = DST_A;
					alu_a = ta_q; alu_b = {16'd0, scale_q[31:16]};
				end
				5'd2: begin
					uop.dst = DST_B;
					alu_a = ta_q; alu_b = sx16(fit_q[15:0]);
				end
				5'd3: begin
					uop.op = ALU_MUL; uop.dst = DST_C;
					alu_a = sx16(fit_q[31:16]); alu_b = K_2048;
				end
				5'd4: begin
					uop.div = 1'b1; uop.div_sgn = 1'b1; uop.dst = DST_D;
					alu_a = tc_q; alu_b = tb_q;
				end
				5'd5: begin
					uop.dst = DST_B5;
					alu_a = ta_q; alu_b = td_q;
				end
				default: begin
					uop.sh = 5'd4; uop.last = 1'b1;
					alu_a = b5_q; alu_b = 32'd8;
				end
			endcase
		end else begin
			case (step_q)
				5'd0: begin
					uop.op = ALU_SUB; uop.dst = DST_A;
					alu_a = b5_q; alu_b = B6_OFFSET;
				end
				5'd1: begin
					uop.op = ALU_MUL; uop.sh = 5'd12; uop.dst = DST_B;
					alu_a = ta_q; alu_b = ta_q;
				end
				5'd2: begin
					uop.op = ALU_MUL; uop.sh = 5'd11; uop.dst = DST_C;
					alu_a = sx16(b2_q); alu_b = tb_q;
				end
				5'd3: begin
					uop.op = ALU_MUL; uop.sh = 5'd11; uop.dst = DST_D;
					alu_a = sx16(ac2_q); alu_b = ta_q;
				end
				5'd4: begin
					uop.dst = DST_C;
					alu_a = tc_q; alu_b = td_q;
				end
				5'd5: begin
					uop.op = ALU_MUL; uop.dst = DST_D;
					alu_a = sx16(ac1_q); alu_b = 32'd4;
				end
				5'd6: begin
					uop.dst = DST_C;
					alu_a = td_q; alu_b = tc_q;
				end
				5'd7: begin
					uop.op = ALU_MUL; uop.dst = DST_C;
					alu_a = tc_q; alu_b = OSS_MUL;
				end
				5'd8: begin
					// B3
					uop.sh = 5'd2; uop.dst = DST_E;
					alu_a = tc_q; alu_b = 32'd2;
				end
				5'd9: begin
					uop.op = ALU_MUL; uop.sh = 5'd13; uop.dst = DST_C;
					alu_a = sx16(ac3_q); alu_b = ta_q;
				end
				5'd10: begin
					uop.op = ALU_MUL; uop.sh = 5'd16; uop.dst = DST_D;
					alu_a = sx16(b1_q); alu_b = tb_q;
				end
				5'd11: begin
					uop.dst = DST_C;
					alu_a = tc_q; alu_b = td_q;
				end
				5'd12: begin
					uop.sh = 5'd2; uop.dst = DST_C;
					alu_a = tc_q; alu_b = 32'd2;
				end
				5'd13: begin
					uop.dst = DST_C;
					alu_a = tc_q; alu_b = X3_BIAS;
				end
				5'd14: begin
					// B4, unsigned
					uop.op = ALU_MUL; uop.sh = 5'd15; uop.lsr = 1'b1; uop.dst = DST_B;
					alu_a = {16'd0, ac4_q}; alu_b = tc_q;
				end
				5'd15: begin
					uop.op = ALU_SUB; uop.dst = DST_A;
					alu_a = {13'd0, raw_q}; alu_b = te_q;
				end
				5'd16: begin
					// B7
					uop.op = ALU_MUL; uop.dst = DST_A;
					alu_a = ta_q; alu_b = UP_SCALE;
				end
				5'd17: begin
					uop.op = ALU_MUL; uop.dst = DST_D;
					alu_a = ta_q; alu_b = 32'd2;
				end
				5'd18: begin
					uop.div = 1'b1; uop.dst = DST_C;
					alu_a = ta_q[31] ? ta_q : td_q; alu_b = tb_q;
				end
				5'd19: begin
					uop.op = ALU_MUL; uop.dst = DST_C;
					alu_a = tc_q; alu_b = ta_q[31] ? 32'd2 : 32'd1;
				end
				5'd20: begin
					uop.sh = 5'd8; uop.dst = DST_D;
					alu_a = tc_q; alu_b = 32'd0;
				end
				5'd21: begin
					uop.op = ALU_MUL; uop.dst = DST_D;
					alu_a = td_q; alu_b = td_q;
				end
				5'd22: begin
					uop.op = ALU_MUL; uop.sh = 5'd16; uop.dst = DST_D;
					alu_a = td_q; alu_b = K_3038;
				end
				5'd23: begin
					uop.op = ALU_MUL; uop.sh = 5'd16; uop.dst = DST_E;
					alu_a = tc_q; alu_b = K_M7357;
				end
				5'd24: begin
					uop.dst = DST_D;
					alu_a = td_q; alu_b = te_q;
				end
				5'd25: begin
					uop.sh = 5'd4; uop.dst = DST_D;
					alu_a = td_q; alu_b = K_3791;
				end
				default: begin
					uop.dst = DST_C; uop.last = 1'b1;
					alu_a = tc_q; alu_b = td_q;
				end
			endcase
		end
	end

	bsc_alu u_alu (
		.op  (uop.op),
		.a   (alu_a),
		.b   (alu_b),
		.sh  (uop.sh),
		.lsr (uop.lsr),
		.y   (alu_y)
	);

	assign div_zero      = (alu_b == 32'd0);
	assign div_ctl.start = (state_q == ST_RUN) && uop.div && !div_zero;
	assign div_ctl.sgn   = uop.div_sgn;

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (alu_a),
		.divisor  (alu_b),
		.sts      (div_sts),
		.quotient (div_q)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// write-back of the working registers
	always_comb begin
		wr_en   = 1'b0;
		wr_data = alu_y;
		if (state_q == ST_RUN) begin
			if (uop.div) begin
				wr_en   = div_zero;
				wr_data = '0;
			end else begin
				wr_en = !uop.last || out_free;
			end
		end else if (state_q == ST_DIVW) begin
			wr_en   = div_sts.done;
			wr_data = div_q;
		end
	end

	// saturate the temperature to 16 bits
	always_comb begin
		if (alu_y[31:15] == {17{alu_y[31]}})
			temp_sat = alu_y[15:0];
		else if (alu_y[31])
			temp_sat = 16'h8000;
		else
			temp_sat = 16'h7FFF;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			err_q   <= 1'b0;
			kind_q  <= CMD_TEMP;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						err_q   <= 1'b0;
						kind_q  <= s_tuser;
					end
				end
				ST_RUN: begin
					if (uop.div) begin
						if (div_zero) begin
							err_q  <= 1'b1;
							step_q <= step_q + 5'd1;
						end else begin
							state_q <= ST_DIVW;
						end
					end else if (uop.last) begin
						if (out_free)
							state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_DIVW: begin
					if (div_sts.done) begin
						state_q <= ST_RUN;
						step_q  <= step_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			raw_q <= s_tdata[18:0];
	end

	// working registers
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (uop.dst)
				DST_A:   ta_q <= wr_data;
				DST_B:   tb_q <= wr_data;
				DST_C:   tc_q <= wr_data;
				DST_D:   td_q <= wr_data;
				DST_E:   te_q <= wr_data;
				default: ;
			endcase
		end
	end

	// kept B5 and calibration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q    <= '0;
			ac1_q   <= '0;
			ac2_q   <= '0;
			ac3_q   <= '0;
			ac4_q   <= '0;
			b1_q    <= '0;
			b2_q    <= '0;
			scale_q <= '0;
			fit_q   <= '0;
		end else begin
			if (wr_en && uop.dst == DST_B5)
				b5_q <= wr_data;
			if (cfg_we) begin
				case (cfg_index)
					REG_AC1:  ac1_q   <= cfg_data[15:0];
					REG_AC2:  ac2_q   <= cfg_data[15:0];
					REG_AC3:  ac3_q   <= cfg_data[15:0];
					REG_AC4:  ac4_q   <= cfg_data[15:0];
					REG_B1:   b1_q    <= cfg_data[15:0];
					REG_B2:   b2_q    <= cfg_data[15:0];
					REG_SCAL: scale_q <= cfg_data;
					REG_FIT:  fit_q   <= cfg_data;
					default:  ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_RUN && uop.last && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && uop.last && out_free) begin
			out_kind_q <= kind_q;
			out_err_q  <= err_q;
			if (kind_q == CMD_TEMP) begin
				out_temp_q  <= err_q ? 16'd0 : temp_sat;
				out_press_q <= '0;
			end else begin
				out_temp_q  <= '0;
				out_press_q <= err_q ? 32'd0 : alu_y;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_press_q, out_temp_q};
	assign m_tuser  = {out_err_q, out_kind_q};

endmodule
